### sv/sme_pkg.sv
// Shared widths and fixed-point constants of the Stokes matrix exponential.
`default_nettype none
package sme_pkg;

    // Root of Q^2+U^2+V^2 (scaled by 256), one bit per cell
    localparam int SQRT_W = 20;
    localparam int RAD_W  = 40;

    // Exponent argument in Q.16 and the split exponent
    localparam int X_W    = 23;
    localparam int N_W    = 10;

    // Taylor series of 2^f, Q1.32 terms and Q2.32 running sum
    localparam int SERIES_TERMS = 13;
    localparam int TERM_W = 33;
    localparam int SUM_W  = 34;
    localparam int E_W    = 64;

    // Division |c|*16*2^32 / r, one quotient bit per cell
    localparam int DIV_Q_W = 33;
    localparam int DIV_R_W = 20;

    localparam logic [36:0] LOG2E_Q36 = 37'd99141248300;
    localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;

endpackage
`default_nettype wire

### sv/sme_sqrt_cell.sv
// One bit of the restoring square root of the scaled polarization power.
`default_nettype none
module sme_sqrt_cell #(
    parameter int J = 19
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [sme_pkg::RAD_W-1:0]   rem_in,
    input  wire logic [sme_pkg::SQRT_W-1:0]  res_in,
    output logic      [sme_pkg::RAD_W-1:0]   rem_out,
    output logic      [sme_pkg::SQRT_W-1:0]  res_out
);

    logic [sme_pkg::RAD_W-1:0]  rem_reg, rem_next;
    logic [sme_pkg::SQRT_W-1:0] res_reg, res_next;
    logic [sme_pkg::RAD_W:0]    trial;

    // (res + 2^J)^2 - res^2 = res*2^(J+1) + 2^(2J)
    always_comb
    begin
        trial = ((sme_pkg::RAD_W+1)'(res_in) << (J + 1))
              | ((sme_pkg::RAD_W+1)'(1) << (2 * J));
        if ({1'b0, rem_in} >= trial)
        begin
            rem_next = sme_pkg::RAD_W'({1'b0, rem_in} - trial);
            res_next = res_in | (sme_pkg::SQRT_W'(1) << J);
        end
        else
        begin
            rem_next = rem_in;
            res_next = res_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign rem_out = rem_reg;
    assign res_out = res_reg;

endmodule
`default_nettype wire

### sv/sme_exp_cell.sv
// One Taylor term of 2^f: multiply by g, divide by K through a reciprocal, accumulate.
`default_nettype none
module sme_exp_cell #(
    parameter int K = 1
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic        [31:0]                g_in,
    input  wire logic signed [sme_pkg::N_W-1:0]    n_in,
    input  wire logic        [sme_pkg::TERM_W-1:0] term_in,
    input  wire logic        [sme_pkg::SUM_W-1:0]  sum_in,
    output logic             [31:0]                g_out,
    output logic signed      [sme_pkg::N_W-1:0]    n_out,
    output logic             [sme_pkg::TERM_W-1:0] term_out,
    output logic             [sme_pkg::SUM_W-1:0]  sum_out
);

    // Exact floor(v/K) for any 32-bit v
    localparam int SH = 32 + $clog2(K);
    localparam logic [32:0] RECIP = 33'(((65'd1 << SH) + 65'(K) - 65'd1) / 65'(K));

    logic        [64:0]                prod_a;
    logic        [64:0]                prod_b;
    logic        [31:0]                quot;

    logic        [31:0]                v_reg;
    logic        [31:0]                g_a_reg;
    logic signed [sme_pkg::N_W-1:0]    n_a_reg;
    logic        [sme_pkg::SUM_W-1:0]  sum_a_reg;

    logic        [31:0]                g_b_reg;
    logic signed [sme_pkg::N_W-1:0]    n_b_reg;
    logic        [sme_pkg::TERM_W-1:0] term_b_reg;
    logic        [sme_pkg::SUM_W-1:0]  sum_b_reg;

    always_comb
    begin
        prod_a = 65'(term_in) * 65'(g_in);
        prod_b = 65'(v_reg) * 65'(RECIP);
        quot   = 32'(prod_b >> SH);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg      <= prod_a[63:32];
            g_a_reg    <= g_in;
            n_a_reg    <= n_in;
            sum_a_reg  <= sum_in;

            term_b_reg <= {1'b0, quot};
            sum_b_reg  <= sum_a_reg + sme_pkg::SUM_W'(quot);
            g_b_reg    <= g_a_reg;
            n_b_reg    <= n_a_reg;
        end
    end

    assign g_out    = g_b_reg;
    assign n_out    = n_b_reg;
    assign term_out = term_b_reg;
    assign sum_out  = sum_b_reg;

endmodule
`default_nettype wire

### sv/sme_exp.sv
// Fixed-point exp(x): Q.16 argument to unsigned Q32.32 through a chain of series cells.
`default_nettype none
module sme_exp (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic signed [sme_pkg::X_W-1:0] x,
    output logic             [sme_pkg::E_W-1:0] e
);

    localparam int TERMS = sme_pkg::SERIES_TERMS;

    logic signed [41:0]             ph_reg;
    logic signed [42:0]             pl_reg;
    logic signed [61:0]             t_w;
    logic        [31:0]             f_reg;
    logic signed [sme_pkg::N_W-1:0] n1_reg;
    logic        [63:0]             gprod;
    logic        [31:0]             g_reg;
    logic signed [sme_pkg::N_W-1:0] n2_reg;

    logic        [31:0]                g_c    [0:TERMS];
    logic signed [sme_pkg::N_W-1:0]    n_c    [0:TERMS];
    logic        [sme_pkg::TERM_W-1:0] term_c [0:TERMS];
    logic        [sme_pkg::SUM_W-1:0]  sum_c  [0:TERMS];

    logic signed [sme_pkg::N_W-1:0] n_l;
    logic        [sme_pkg::N_W-1:0] n_neg;
    logic        [sme_pkg::E_W-1:0] e_next;
    logic        [sme_pkg::E_W-1:0] e_reg;

    // t = x*log2(e) in Q.52; n is its floor, f its fraction
    always_comb
    begin
        t_w = $signed({ph_reg[41], ph_reg, 19'b0})
            + $signed({{19{pl_reg[42]}}, pl_reg});
        gprod = 64'(f_reg) * 64'(sme_pkg::LN2_Q32);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg <= x * $signed({1'b0, sme_pkg::LOG2E_Q36[36:19]});
            pl_reg <= x * $signed({1'b0, sme_pkg::LOG2E_Q36[18:0]});
            f_reg  <= t_w[51:20];
            n1_reg <= t_w[61:52];
            g_reg  <= gprod[63:32];
            n2_reg <= n1_reg;
        end
    end

    assign g_c[0]    = g_reg;
    assign n_c[0]    = n2_reg;
    assign term_c[0] = sme_pkg::TERM_W'(64'd1 << 32);
    assign sum_c[0]  = sme_pkg::SUM_W'(64'd1 << 32);

    for (genvar k = 0; k < TERMS; k++)
    begin : g_term
        sme_exp_cell #(
            .K (k + 1)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .g_in     (g_c[k]),
            .n_in     (n_c[k]),
            .term_in  (term_c[k]),
            .sum_in   (sum_c[k]),
            .g_out    (g_c[k+1]),
            .n_out    (n_c[k+1]),
            .term_out (term_c[k+1]),
            .sum_out  (sum_c[k+1])
        );
    end

    // Scale by 2^n; clamp exponents outside the 64-bit range
    always_comb
    begin
        n_l   = n_c[TERMS];
        n_neg = sme_pkg::N_W'(0) - n_l;
        if (n_l > sme_pkg::N_W'(31))
        begin
            e_next = '1;
        end
        else if (n_l >= 0)
        begin
            e_next = sme_pkg::E_W'(sum_c[TERMS]) << n_l[5:0];
        end
        else if (n_l < -sme_pkg::N_W'(63))
        begin
            e_next = '0;
        end
        else
        begin
            e_next = sme_pkg::E_W'(sum_c[TERMS]) >> n_neg[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= e_next;
        end
    end

    assign e = e_reg;

endmodule
`default_nettype wire

### sv/sme_div_cell.sv
// One quotient bit of the restoring divide of a scaled component by r.
`default_nettype none
module sme_div_cell (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [sme_pkg::DIV_R_W-1:0]   rem_in,
    input  wire logic                          bit_in,
    input  wire logic [sme_pkg::DIV_R_W-1:0]   den_in,
    input  wire logic [sme_pkg::DIV_Q_W-1:0]   quo_in,
    output logic      [sme_pkg::DIV_R_W-1:0]   rem_out,
    output logic      [sme_pkg::DIV_R_W-1:0]   den_out,
    output logic      [sme_pkg::DIV_Q_W-1:0]   quo_out
);

    logic [sme_pkg::DIV_R_W:0]   trial;
    logic [sme_pkg::DIV_R_W-1:0] rem_next;
    logic                        qbit;
    logic [sme_pkg::DIV_R_W-1:0] rem_reg;
    logic [sme_pkg::DIV_R_W-1:0] den_reg;
    logic [sme_pkg::DIV_Q_W-1:0] quo_reg;

    always_comb
    begin
        trial = {rem_in, bit_in};
        qbit  = (trial >= {1'b0, den_in});
        if (qbit)
        begin
            rem_next = sme_pkg::DIV_R_W'(trial - {1'b0, den_in});
        end
        else
        begin
            rem_next = sme_pkg::DIV_R_W'(trial);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= {quo_in[sme_pkg::DIV_Q_W-2:0], qbit};
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule
`default_nettype wire

### sv/stokes_matrix_exponential.sv
// Top level: pipelined exponential of the 2x2 Stokes polarization matrix.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+--------------------------------------
//   pixel    | pixel_valid / pixel_ready   | stokes_i, stokes_q, stokes_u, stokes_v
//   result   | result_valid / result_ready | out_i, out_q, out_u, out_v, overflow
//
// One pixel enters per cycle unless the pipeline is stalled. The depth is set by the
// 20-cell square root chain, the 33-cell divider chains and the final 97-bit scaling
// multiply.
// rst_n clears only the stage valid bits; data registers carry no reset.
// The whole pipeline holds while the result register is full and result_ready is
// low; pixel_ready is low only in that case.
`default_nettype none
module stokes_matrix_exponential (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pixel_valid,
    output logic                    pixel_ready,
    input  wire logic signed [15:0] stokes_i,
    input  wire logic signed [15:0] stokes_q,
    input  wire logic signed [15:0] stokes_u,
    input  wire logic signed [15:0] stokes_v,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic             [31:0] out_i,
    output logic signed      [31:0] out_q,
    output logic signed      [31:0] out_u,
    output logic signed      [31:0] out_v,
    output logic                    overflow
);

    localparam int SQ_N   = sme_pkg::SQRT_W;   // square root cells
    localparam int DV_N   = sme_pkg::DIV_Q_W;  // divider cells per component
    localparam int NCOMP  = 3;
    localparam int DEPTH  = 58;
    localparam int S_DLY  = 2;                 // align exp results with the quotients

    typedef struct packed {
        logic signed [15:0] i;
        logic signed [15:0] q;
        logic signed [15:0] u;
        logic signed [15:0] v;
    } side_t;

    typedef struct packed {
        logic [NCOMP-1:0] neg;
        logic [NCOMP-1:0] zero;
    } flags_t;

    typedef struct packed {
        logic [31:0]           oi;
        logic                  ovf;
        logic [sme_pkg::E_W-1:0] sh;
    } hyp_t;

    // Stall control: advance every stage unless the result is blocked
    logic             en;
    logic [DEPTH-1:0] vld_reg;

    assign en           = ~vld_reg[DEPTH-1] | result_ready;
    assign pixel_ready  = en;
    assign result_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], pixel_valid};
        end
    end

    // Stage 0: capture the pixel and form Q^2+U^2+V^2
    logic signed [31:0] sq_q, sq_u, sq_v;
    logic        [31:0] pow_reg;
    side_t              side0_reg;

    always_comb
    begin
        sq_q = stokes_q * stokes_q;
        sq_u = stokes_u * stokes_u;
        sq_v = stokes_v * stokes_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pow_reg   <= 32'(sq_q) + 32'(sq_u) + 32'(sq_v);
            side0_reg <= {stokes_i, stokes_q, stokes_u, stokes_v};
        end
    end

    // Square root chain: r = floor(sqrt(pow * 256)), MSB first
    logic [sme_pkg::RAD_W-1:0]  rad_c [0:SQ_N];
    logic [sme_pkg::SQRT_W-1:0] res_c [0:SQ_N];
    side_t                      side_dly_reg [0:SQ_N-1];

    assign rad_c[0] = {pow_reg, 8'b0};
    assign res_c[0] = '0;

    for (genvar j = 0; j < SQ_N; j++)
    begin : g_sqrt
        sme_sqrt_cell #(
            .J (SQ_N - 1 - j)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (rad_c[j]),
            .res_in  (res_c[j]),
            .rem_out (rad_c[j+1]),
            .res_out (res_c[j+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly_reg[0] <= side0_reg;
            for (int k = 1; k < SQ_N; k++)
            begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    // Form a+r, a-r, the scaled magnitudes, their signs and zero flags
    side_t                             sd;
    logic signed [sme_pkg::X_W-1:0]    a_w, r_w;
    logic        [15:0]                abs_w  [0:NCOMP-1];
    logic signed [15:0]                comp_w [0:NCOMP-1];
    logic signed [sme_pkg::X_W-1:0]    xp_reg, xm_reg;
    logic        [sme_pkg::DIV_R_W-1:0] r_reg;
    logic        [sme_pkg::DIV_R_W-1:0] mag_reg [0:NCOMP-1];
    flags_t                            flags_reg;

    always_comb
    begin
        sd        = side_dly_reg[SQ_N-1];
        a_w       = {{3{sd.i[15]}}, sd.i, 4'b0};
        r_w       = {3'b0, res_c[SQ_N]};
        comp_w[0] = sd.q;
        comp_w[1] = sd.u;
        comp_w[2] = sd.v;
        for (int k = 0; k < NCOMP; k++)
        begin
            abs_w[k] = comp_w[k][15] ? (16'd0 - comp_w[k]) : comp_w[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xp_reg <= a_w + r_w;
            xm_reg <= a_w - r_w;
            r_reg  <= res_c[SQ_N];
            for (int k = 0; k < NCOMP; k++)
            begin
                mag_reg[k]        <= {abs_w[k], 4'b0};
                flags_reg.neg[k]  <= comp_w[k][15];
                flags_reg.zero[k] <= (comp_w[k] == 16'sd0);
            end
        end
    end

    // exp(a+r) and exp(a-r)
    logic [sme_pkg::E_W-1:0] ep, em;

    sme_exp u_exp_p (
        .clk (clk),
        .en  (en),
        .x   (xp_reg),
        .e   (ep)
    );

    sme_exp u_exp_m (
        .clk (clk),
        .en  (en),
        .x   (xm_reg),
        .e   (em)
    );

    // cosh and sinh terms
    logic [sme_pkg::E_W:0]   ch_w;
    hyp_t                    hyp_next;
    hyp_t                    hyp_dly_reg [0:S_DLY];

    always_comb
    begin
        ch_w = (sme_pkg::E_W+1)'(ep >> 1) + (sme_pkg::E_W+1)'(em >> 1)
             + (sme_pkg::E_W+1)'(ep & em & 64'd1);
        hyp_next.ovf = |ch_w[sme_pkg::E_W:48];
        hyp_next.oi  = hyp_next.ovf ? 32'hFFFF_FFFF : ch_w[47:16];
        hyp_next.sh  = (ep >= em) ? ((ep - em) >> 1) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hyp_dly_reg[0] <= hyp_next;
            for (int k = 1; k <= S_DLY; k++)
            begin
                hyp_dly_reg[k] <= hyp_dly_reg[k-1];
            end
        end
    end

    // Divider chains: rho = |c|*16*2^32 / r, one quotient bit per cell
    logic [sme_pkg::DIV_R_W-1:0] drem_c [0:NCOMP-1][0:DV_N];
    logic [sme_pkg::DIV_R_W-1:0] dden_c [0:NCOMP-1][0:DV_N];
    logic [sme_pkg::DIV_Q_W-1:0] dquo_c [0:NCOMP-1][0:DV_N];
    flags_t                      flags_dly_reg [0:DV_N-1];

    for (genvar c = 0; c < NCOMP; c++)
    begin : g_comp
        assign drem_c[c][0] = mag_reg[c] >> 1;
        assign dden_c[c][0] = r_reg;
        assign dquo_c[c][0] = '0;
        for (genvar d = 0; d < DV_N; d++)
        begin : g_div
            sme_div_cell u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (drem_c[c][d]),
                .bit_in  ((d == 0) ? mag_reg[c][0] : 1'b0),
                .den_in  (dden_c[c][d]),
                .quo_in  (dquo_c[c][d]),
                .rem_out (drem_c[c][d+1]),
                .den_out (dden_c[c][d+1]),
                .quo_out (dquo_c[c][d+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_dly_reg[0] <= flags_reg;
            for (int k = 1; k < DV_N; k++)
            begin
                flags_dly_reg[k] <= flags_dly_reg[k-1];
            end
        end
    end

    // sinh * rho in two partial products, then the full 97-bit sum
    hyp_t        hyp_a_reg, hyp_b_reg;
    flags_t      flags_a_reg, flags_b_reg;
    logic [64:0] plo_reg [0:NCOMP-1];
    logic [64:0] phi_reg [0:NCOMP-1];
    logic [96:0] full_reg [0:NCOMP-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hyp_a_reg   <= hyp_dly_reg[S_DLY];
            flags_a_reg <= flags_dly_reg[DV_N-1];
            hyp_b_reg   <= hyp_a_reg;
            flags_b_reg <= flags_a_reg;
            for (int k = 0; k < NCOMP; k++)
            begin
                plo_reg[k]  <= 65'(hyp_dly_reg[S_DLY].sh[31:0]) * 65'(dquo_c[k][DV_N]);
                phi_reg[k]  <= 65'(hyp_dly_reg[S_DLY].sh[63:32]) * 65'(dquo_c[k][DV_N]);
                full_reg[k] <= {phi_reg[k], 32'b0} + 97'(plo_reg[k]);
            end
        end
    end

    // Saturate, apply signs, drop zero components
    logic [48:0]       val_w  [0:NCOMP-1];
    logic [31:0]       lim_w  [0:NCOMP-1];
    logic [31:0]       mag_w  [0:NCOMP-1];
    logic [31:0]       res_w  [0:NCOMP-1];
    logic [NCOMP-1:0]  sat_w;
    logic [31:0]       out_i_reg;
    logic [31:0]       out_c_reg [0:NCOMP-1];
    logic              ovf_reg;

    always_comb
    begin
        for (int k = 0; k < NCOMP; k++)
        begin
            val_w[k] = full_reg[k][96:48];
            lim_w[k] = flags_b_reg.neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            sat_w[k] = ~flags_b_reg.zero[k] && (val_w[k] > 49'(lim_w[k]));
            mag_w[k] = sat_w[k] ? lim_w[k] : val_w[k][31:0];
            if (flags_b_reg.zero[k])
            begin
                res_w[k] = '0;
            end
            else if (flags_b_reg.neg[k])
            begin
                res_w[k] = 32'd0 - mag_w[k];
            end
            else
            begin
                res_w[k] = mag_w[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_i_reg <= hyp_b_reg.oi;
            ovf_reg   <= hyp_b_reg.ovf | (|sat_w);
            for (int k = 0; k < NCOMP; k++)
            begin
                out_c_reg[k] <= res_w[k];
            end
        end
    end

    assign out_i    = out_i_reg;
    assign out_q    = out_c_reg[0];
    assign out_u    = out_c_reg[1];
    assign out_v    = out_c_reg[2];
    assign overflow = ovf_reg;

endmodule
`default_nettype wire
